/* design/gradient_histogram_accumulator_defines.svh */
// Assertion macros for the gradient histogram accumulator.
`ifndef GRADIENT_HISTOGRAM_ACCUMULATOR_DEFINES_SVH
`define GRADIENT_HISTOGRAM_ACCUMULATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define GHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define GHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define GHA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* design/ghacc_pkg.sv */
package ghacc_pkg;

  localparam int DEF_NUM_FEATURES = 16;
  localparam int DEF_BIN_COUNT    = 256;

  // opcodes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ACCUM  = 2'd1;
  localparam logic [1:0] OP_RDBIN  = 2'd2;
  localparam logic [1:0] OP_RDTOT  = 2'd3;

  // one RAM word holds gradient, hessian and weight sums
  localparam int BIN_WIDTH = 64 + 64 + 48;

  // divider numerator width: 63-bit value shifted left by 12, plus one
  localparam int DIV_STEPS = 76;

  localparam logic [62:0] MAX63 = {63{1'b1}};

  // signed 64-bit saturating add; msb of result is the overflow flag
  function automatic logic [64:0] sat_add_s64(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      return {1'b1, s[64] ? {1'b1, 63'd0} : {1'b0, MAX63}};
    end
    return {1'b0, s[63:0]};
  endfunction

  // unsigned 48-bit saturating add of a 16-bit increment
  function automatic logic [48:0] sat_add_u48(logic [47:0] a, logic [15:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {33'd0, b};
    if (s[48]) begin
      return {1'b1, {48{1'b1}}};
    end
    return {1'b0, s[47:0]};
  endfunction

endpackage

/* design/ghacc_ram.sv */
module ghacc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* design/gradient_histogram_accumulator.sv */
// Gradient histogram accumulator for one tree node.
// Request channel: start with opcode_i and the sample fields; a request is
// taken at a rising edge with start high and busy low. Results come out on
// the *_sum_o, row_count_o, grad_var_o and saturated_o ports for
// one cycle, marked by result_valid_o; the receiver cannot hold them off.
// Only read-bin and read-totals requests produce a result.
// Per request:
//   accumulate: busy through the ACC and SQ states; no new request is
//     taken meanwhile. The bin sums live in one RAM with a registered read;
//     the read, the saturating add and the write back form the loop, then
//     the squared gradient is added to the node totals.
//   read bin: the registered RAM read is copied to the result registers.
//   read totals: two 76-step restoring divisions when the weight total is
//     nonzero, then a 64x64 square in four 32x32 partial products, skipped
//     when the mean exceeds 64 bits; with a zero weight total, neither.
//   clear: a pass writes zero to every bin, one entry per cycle, busy throughout.
// Reset clears the node totals and the flag and starts that same clearing
// pass; busy stays high until it ends.
`include "gradient_histogram_accumulator_defines.svh"

module gradient_histogram_accumulator #(
  parameter int NUM_FEATURES = ghacc_pkg::DEF_NUM_FEATURES,
  parameter int BIN_COUNT    = ghacc_pkg::DEF_BIN_COUNT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic [3:0]         feature_index_i,
  input  logic [7:0]         bin_index_i,
  input  logic               count_row_i,
  input  logic signed [23:0] gradient_i,
  input  logic signed [23:0] hessian_i,
  input  logic [15:0]        weight_i,
  output logic               result_valid_o,
  output logic signed [63:0] grad_sum_o,
  output logic signed [63:0] hess_sum_o,
  output logic [47:0]        weight_sum_o,
  output logic [31:0]        row_count_o,
  output logic [62:0]        grad_var_o,
  output logic               saturated_o
);

  import ghacc_pkg::*;

  localparam int DEPTH = NUM_FEATURES * BIN_COUNT;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLR   = 4'd1;
  localparam logic [3:0] ST_ACC   = 4'd2;
  localparam logic [3:0] ST_SQ    = 4'd3;
  localparam logic [3:0] ST_RDBIN = 4'd4;
  localparam logic [3:0] ST_DIVS  = 4'd5;
  localparam logic [3:0] ST_DIVM  = 4'd6;
  localparam logic [3:0] ST_MUL   = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  logic [3:0]  state_q;
  logic [AW-1:0] clr_cnt_q;
  logic [6:0]  div_cnt_q;
  logic [2:0]  mul_cnt_q;
  logic        accept;

  // node totals
  logic [63:0] tot_g_q, tot_h_q;
  logic [47:0] tot_w_q;
  logic [62:0] tot_sq_q;
  logic [31:0] tot_cnt_q;
  logic        flag_q;

  // captured request
  logic [AW-1:0] idx_q;
  logic        in_range_q, count_q;
  logic [63:0] wg_q, wh_q;
  logic [15:0] w_q;
  logic [47:0] sqp_q;
  logic [35:0] sq_q;

  // variance datapath
  logic [75:0]  n_q, s_q;
  logic [47:0]  rem_q;
  logic [63:0]  m_q, pp_q;
  logic [1:0]   pp_sh_q;
  logic [127:0] acc_q;

  // result registers
  logic        valid_q;
  logic [63:0] out_g_q, out_h_q;
  logic [47:0] out_w_q;
  logic [31:0] out_cnt_q;
  logic [62:0] out_var_q;
  logic        out_sat_q;

  // request decode
  logic          in_range;
  logic [AW-1:0] idx;
  logic signed [40:0] pg, ph;
  logic [23:0]   gm;
  logic [47:0]   sqp;

  assign accept   = start && !busy;
  assign busy     = (state_q != ST_IDLE);
  assign in_range = (32'(feature_index_i) < 32'(NUM_FEATURES)) &&
                    (32'(bin_index_i) < 32'(BIN_COUNT));
  assign idx      = AW'(32'(feature_index_i) * 32'(BIN_COUNT) + 32'(bin_index_i));
  assign pg       = $signed({1'b0, weight_i}) * gradient_i;
  assign ph       = $signed({1'b0, weight_i}) * hessian_i;
  assign gm       = gradient_i[23] ? 24'(-gradient_i) : gradient_i;
  assign sqp      = 48'(gm) * 48'(gm);

  // bin RAM
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [BIN_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [64:0]          bin_g_new, bin_h_new;
  logic [48:0]          bin_w_new;

  assign bin_g_new = sat_add_s64(ram_rdata[175:112], wg_q);
  assign bin_h_new = sat_add_s64(ram_rdata[111:48], wh_q);
  assign bin_w_new = sat_add_u48(ram_rdata[47:0], w_q);

  assign ram_we    = (state_q == ST_CLR) || ((state_q == ST_ACC) && in_range_q);
  assign ram_waddr = (state_q == ST_CLR) ? clr_cnt_q : idx_q;
  assign ram_wdata = (state_q == ST_CLR) ? '0 :
                     {bin_g_new[63:0], bin_h_new[63:0], bin_w_new[47:0]};

  ghacc_ram #(
    .WIDTH (BIN_WIDTH),
    .DEPTH (DEPTH)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx),
    .rdata_o (ram_rdata)
  );

  // node total adders
  logic [64:0] tot_g_new, tot_h_new;
  logic [48:0] tot_w_new;
  logic [63:0] sqf, sq_sum;
  logic [32:0] cnt_sum;

  assign tot_g_new = sat_add_s64(tot_g_q, wg_q);
  assign tot_h_new = sat_add_s64(tot_h_q, wh_q);
  assign tot_w_new = sat_add_u48(tot_w_q, w_q);
  assign cnt_sum   = {1'b0, tot_cnt_q} + 33'd1;
  assign sqf       = 64'(sqp_q) * 64'(w_q);
  assign sq_sum    = 64'(tot_sq_q) + 64'(sq_q);

  // restoring divider step, divisor is the node weight total
  logic [48:0] div_r;
  logic        div_ge;
  logic [47:0] div_rem;
  logic [75:0] div_n;
  logic [63:0] gmag;

  assign div_r   = {rem_q, n_q[75]};
  assign div_ge  = div_r >= {1'b0, tot_w_q};
  assign div_rem = div_ge ? 48'(div_r - {1'b0, tot_w_q}) : div_r[47:0];
  assign div_n   = {n_q[74:0], div_ge};
  assign gmag    = tot_g_q[63] ? (64'd0 - tot_g_q) : tot_g_q;

  // partial products of the mean square
  logic [31:0]  pp_a, pp_b;
  logic [127:0] pp_shifted;

  assign pp_a = mul_cnt_q[1] ? m_q[63:32] : m_q[31:0];
  assign pp_b = mul_cnt_q[0] ? m_q[63:32] : m_q[31:0];

  always_comb begin
    case (pp_sh_q)
      2'd0:    pp_shifted = {64'd0, pp_q};
      2'd1:    pp_shifted = {32'd0, pp_q, 32'd0};
      default: pp_shifted = {pp_q, 64'd0};
    endcase
  end

  // final clamp: S minus floor(M*M / 2^16)
  logic [111:0] msq, s_ext, diff;
  logic [62:0]  var_val;

  assign msq   = acc_q[127:16];
  assign s_ext = {36'd0, s_q};
  assign diff  = s_ext - msq;

  always_comb begin
    if (s_ext <= msq) begin
      var_val = '0;
    end else if (diff[111:63] != '0) begin
      var_val = MAX63;
    end else begin
      var_val = diff[62:0];
    end
  end

  // control and node state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_cnt_q <= '0;
      div_cnt_q <= '0;
      mul_cnt_q <= '0;
      tot_g_q   <= '0;
      tot_h_q   <= '0;
      tot_w_q   <= '0;
      tot_sq_q  <= '0;
      tot_cnt_q <= '0;
      flag_q    <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      valid_q <= (state_q == ST_RDBIN) || (state_q == ST_FIN);
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (opcode_i)
              OP_CLEAR: begin
                state_q   <= ST_CLR;
                clr_cnt_q <= '0;
                tot_g_q   <= '0;
                tot_h_q   <= '0;
                tot_w_q   <= '0;
                tot_sq_q  <= '0;
                tot_cnt_q <= '0;
                flag_q    <= 1'b0;
              end
              OP_ACCUM: state_q <= ST_ACC;
              OP_RDBIN: state_q <= ST_RDBIN;
              default: begin
                div_cnt_q <= '0;
                state_q   <= (tot_w_q == '0) ? ST_FIN : ST_DIVS;
              end
            endcase
          end
        end
        ST_CLR: begin
          clr_cnt_q <= clr_cnt_q + AW'(1);
          if (clr_cnt_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_ACC: begin
          if (in_range_q) begin
            flag_q <= flag_q | bin_g_new[64] | bin_h_new[64] | bin_w_new[48] |
                      (count_q & (tot_g_new[64] | tot_h_new[64] | tot_w_new[48] |
                                  cnt_sum[32]));
          end else if (count_q) begin
            flag_q <= flag_q | tot_g_new[64] | tot_h_new[64] | tot_w_new[48] |
                      cnt_sum[32];
          end
          if (count_q) begin
            tot_g_q   <= tot_g_new[63:0];
            tot_h_q   <= tot_h_new[63:0];
            tot_w_q   <= tot_w_new[47:0];
            tot_cnt_q <= cnt_sum[32] ? {32{1'b1}} : cnt_sum[31:0];
          end
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          if (count_q) begin
            tot_sq_q <= sq_sum[63] ? MAX63 : sq_sum[62:0];
            flag_q   <= flag_q | sq_sum[63];
          end
          state_q <= ST_IDLE;
        end
        ST_RDBIN: begin
          state_q <= ST_IDLE;
        end
        ST_DIVS: begin
          if (div_cnt_q == 7'(DIV_STEPS - 1)) begin
            div_cnt_q <= '0;
            state_q   <= ST_DIVM;
          end else begin
            div_cnt_q <= div_cnt_q + 7'd1;
          end
        end
        ST_DIVM: begin
          div_cnt_q <= div_cnt_q + 7'd1;
          mul_cnt_q <= '0;
          if (div_cnt_q == 7'(DIV_STEPS - 1)) begin
            state_q <= (div_n[75:64] != '0) ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL: begin
          mul_cnt_q <= mul_cnt_q + 3'd1;
          if (mul_cnt_q == 3'd4) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q      <= idx;
      in_range_q <= in_range;
      count_q    <= count_row_i;
      wg_q       <= {{35{pg[40]}}, pg[40:12]};
      wh_q       <= {{35{ph[40]}}, ph[40:12]};
      w_q        <= weight_i;
      sqp_q      <= sqp;
      rem_q      <= '0;
      n_q        <= {1'b0, tot_sq_q, 12'd0};
      s_q        <= '0;
      acc_q      <= '0;
    end
    if (state_q == ST_ACC) begin
      sq_q <= sqf[63:28];
    end
    if (state_q == ST_DIVS) begin
      if (div_cnt_q == 7'(DIV_STEPS - 1)) begin
        s_q   <= div_n;
        n_q   <= {gmag, 12'd0};
        rem_q <= '0;
      end else begin
        n_q   <= div_n;
        rem_q <= div_rem;
      end
    end
    if (state_q == ST_DIVM) begin
      n_q   <= div_n;
      rem_q <= div_rem;
      if (div_cnt_q == 7'(DIV_STEPS - 1)) begin
        m_q <= div_n[63:0];
        // a mean of 2^64 or more forces a zero result
        if (div_n[75:64] != '0) begin
          acc_q <= {128{1'b1}};
        end
      end
    end
    if (state_q == ST_MUL) begin
      pp_q    <= 64'(pp_a) * 64'(pp_b);
      pp_sh_q <= {1'b0, mul_cnt_q[1]} + {1'b0, mul_cnt_q[0]};
      if (mul_cnt_q != 3'd0) begin
        acc_q <= acc_q + pp_shifted;
      end
    end
    if (state_q == ST_RDBIN) begin
      out_g_q   <= in_range_q ? ram_rdata[175:112] : '0;
      out_h_q   <= in_range_q ? ram_rdata[111:48] : '0;
      out_w_q   <= in_range_q ? ram_rdata[47:0] : '0;
      out_cnt_q <= '0;
      out_var_q <= '0;
      out_sat_q <= flag_q;
    end
    if (state_q == ST_FIN) begin
      out_g_q   <= tot_g_q;
      out_h_q   <= tot_h_q;
      out_w_q   <= tot_w_q;
      out_cnt_q <= tot_cnt_q;
      out_var_q <= var_val;
      out_sat_q <= flag_q;
    end
  end

  assign result_valid_o = valid_q;
  assign grad_sum_o     = out_g_q;
  assign hess_sum_o     = out_h_q;
  assign weight_sum_o   = out_w_q;
  assign row_count_o    = out_cnt_q;
  assign grad_var_o     = out_var_q;
  assign saturated_o    = out_sat_q;

  `GHA_ASSERT_IMP(a_result_after_busy, clk_i, rst_ni, result_valid_o, $past(busy),
                  "result without a preceding busy cycle")
  `GHA_ASSERT_NXT(a_accum_updates_bin, clk_i, rst_ni, accept && opcode_i == OP_ACCUM,
                  state_q == ST_ACC, "accumulate did not reach the bin update")
  `GHA_ASSERT_IMP(a_clear_writes, clk_i, rst_ni, state_q == ST_CLR,
                  ram_we && ram_wdata == '0, "clearing pass not writing zero")
  `GHA_ASSERT_NXT(a_clear_zero_totals, clk_i, rst_ni, accept && opcode_i == OP_CLEAR,
                  tot_cnt_q == '0 && !flag_q && busy, "clear left node state")

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
  import ghacc_pkg::*;

  localparam int  STORE_DEPTH = DEF_NUM_FEATURES * DEF_BIN_COUNT;
  localparam int  CYCLE_LIMIT = 3000000;
  localparam logic [63:0] LIM48 = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] LIM63 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LIM32 = 64'hFFFF_FFFF;

  typedef struct packed {
    logic signed [63:0] grad;
    logic signed [63:0] hess;
    logic [47:0]        wsum;
    logic [31:0]        rows;
    logic [62:0]        var_q16;
    logic               sat;
  } read_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         opcode_i = OP_CLEAR;
  logic [3:0]         feature_index_i = '0;
  logic [7:0]         bin_index_i = '0;
  logic               count_row_i = 1'b0;
  logic signed [23:0] gradient_i = '0;
  logic signed [23:0] hessian_i = '0;
  logic [15:0]        weight_i = '0;
  logic               result_valid_o;
  logic signed [63:0] grad_sum_o;
  logic signed [63:0] hess_sum_o;
  logic [47:0]        weight_sum_o;
  logic [31:0]        row_count_o;
  logic [62:0]        grad_var_o;
  logic               saturated_o;

  // shadow copy of the histogram and node totals
  logic signed [63:0] hist_grad [STORE_DEPTH];
  logic signed [63:0] hist_hess [STORE_DEPTH];
  logic [47:0]        hist_wt   [STORE_DEPTH];
  logic signed [63:0] tot_grad;
  logic signed [63:0] tot_hess;
  logic [47:0]        tot_wt;
  logic [63:0]        tot_sq;
  logic [31:0]        tot_rows;
  logic               sat_flag;

  read_result_t pending_reads [$];
  int unsigned  error_count = 0;
  longint unsigned cycle_count = 0;

  gradient_histogram_accumulator i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .opcode_i           (opcode_i),
    .feature_index_i    (feature_index_i),
    .bin_index_i        (bin_index_i),
    .count_row_i        (count_row_i),
    .gradient_i         (gradient_i),
    .hessian_i          (hessian_i),
    .weight_i           (weight_i),
    .result_valid_o     (result_valid_o),
    .grad_sum_o         (grad_sum_o),
    .hess_sum_o         (hess_sum_o),
    .weight_sum_o       (weight_sum_o),
    .row_count_o        (row_count_o),
    .grad_var_o         (grad_var_o),
    .saturated_o        (saturated_o)
  );

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // saturating adds; any clamp sets the sticky flag
  function automatic logic signed [63:0] sadd64(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_flag = 1'b1;
      return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

  function automatic logic [63:0] uadd_lim(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
    if (a > lim || b > lim - a) begin
      sat_flag = 1'b1;
      return lim;
    end
    return a + b;
  endfunction

  function automatic void clear_histogram();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      hist_grad[i] = '0;
      hist_hess[i] = '0;
      hist_wt[i]   = '0;
    end
    tot_grad = '0;
    tot_hess = '0;
    tot_wt   = '0;
    tot_sq   = '0;
    tot_rows = '0;
    sat_flag = 1'b0;
  endfunction

  // max(0, Q/W - (G/W)^2) in Q.16, clamped to 63 bits
  function automatic logic [62:0] node_variance();
    logic [127:0] wd, gmag, s_q, m_q, msq, diff;
    if (tot_wt == 0) return '0;
    wd   = {80'd0, tot_wt};
    gmag = tot_grad[63] ? {64'd0, -tot_grad} : {64'd0, tot_grad};
    s_q  = ({64'd0, tot_sq} << 12) / wd;
    m_q  = (gmag << 12) / wd;
    if (m_q[127:64] != 0) return '0;
    msq = (m_q * m_q) >> 16;
    if (s_q <= msq) return '0;
    diff = s_q - msq;
    if (diff > {64'd0, LIM63}) return LIM63[62:0];
    return diff[62:0];
  endfunction

  // update the shadow state for one accepted request
  function automatic void predict_histogram(logic [1:0] op, logic [3:0] feat, logic [7:0] bin,
                                            logic cnt, logic signed [23:0] g,
                                            logic signed [23:0] h, logic [15:0] w);
    int                 idx;
    longint             wg, wh;
    logic [63:0]        gm, sq;
    read_result_t       r;
    idx = int'(feat) * DEF_BIN_COUNT + int'(bin);
    case (op)
      OP_CLEAR: clear_histogram();
      OP_ACCUM: begin
        wg = (longint'(w) * longint'(g)) >>> 12;
        wh = (longint'(w) * longint'(h)) >>> 12;
        hist_grad[idx] = sadd64(hist_grad[idx], wg);
        hist_hess[idx] = sadd64(hist_hess[idx], wh);
        hist_wt[idx]   = 48'(uadd_lim({16'd0, hist_wt[idx]}, {48'd0, w}, LIM48));
        if (cnt) begin
          gm       = g[23] ? 64'(-longint'(g)) : 64'(longint'(g));
          sq       = (gm * gm * {48'd0, w}) >> 28;
          tot_grad = sadd64(tot_grad, wg);
          tot_hess = sadd64(tot_hess, wh);
          tot_wt   = 48'(uadd_lim({16'd0, tot_wt}, {48'd0, w}, LIM48));
          tot_sq   = uadd_lim(tot_sq, sq, LIM63);
          tot_rows = 32'(uadd_lim({32'd0, tot_rows}, 64'd1, LIM32));
        end
      end
      OP_RDBIN: begin
        r.grad    = hist_grad[idx];
        r.hess    = hist_hess[idx];
        r.wsum    = hist_wt[idx];
        r.rows    = '0;
        r.var_q16 = '0;
        r.sat     = sat_flag;
        pending_reads = {pending_reads, r};
      end
      default: begin
        r.grad    = tot_grad;
        r.hess    = tot_hess;
        r.wsum    = tot_wt;
        r.rows    = tot_rows;
        r.var_q16 = node_variance();
        r.sat     = sat_flag;
        pending_reads = {pending_reads, r};
      end
    endcase
  endfunction

  // compare every result strobe against the oldest expected read
  always @(posedge clk_i) begin
    read_result_t e;
    if (rst_ni && result_valid_o) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result");
        error_count++;
      end else begin
        e = pending_reads.pop_front();
        if (grad_sum_o !== e.grad) begin
          $error("grad_sum exp %0d got %0d", e.grad, grad_sum_o);
          error_count++;
        end
        if (hess_sum_o !== e.hess) begin
          $error("hess_sum exp %0d got %0d", e.hess, hess_sum_o);
          error_count++;
        end
        if (weight_sum_o !== e.wsum) begin
          $error("weight_sum exp %0d got %0d", e.wsum, weight_sum_o);
          error_count++;
        end
        if (row_count_o !== e.rows) begin
          $error("row_count exp %0d got %0d", e.rows, row_count_o);
          error_count++;
        end
        if (grad_var_o !== e.var_q16) begin
          $error("grad_var exp %0d got %0d", e.var_q16, grad_var_o);
          error_count++;
        end
        if (saturated_o !== e.sat) begin
          $error("saturated exp %0d got %0d", e.sat, saturated_o);
          error_count++;
        end
      end
    end
  end

  // drive one request at the falling edge; returns at the falling edge after
  // acceptance with start still high, so back-to-back requests need no toggle
  task automatic send_request(logic [1:0] op, logic [3:0] feat, logic [7:0] bin, logic cnt,
                              logic signed [23:0] g, logic signed [23:0] h, logic [15:0] w);
    start           <= 1'b1;
    opcode_i        <= op;
    feature_index_i <= feat;
    bin_index_i     <= bin;
    count_row_i     <= cnt;
    gradient_i      <= g;
    hessian_i       <= h;
    weight_i        <= w;
    do @(posedge clk_i); while (busy);
    predict_histogram(op, feat, bin, cnt, g, h, w);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // hold off until every pending read has come back
  task automatic drain_reads();
    start <= 1'b0;
    do @(negedge clk_i); while (pending_reads.size() != 0);
  endtask

  task automatic test_directed();
    send_request(OP_RDTOT, 4'd0, 8'd0, 1'b0, '0, '0, '0);          // zero weight total
    send_request(OP_RDBIN, 4'd15, 8'd255, 1'b0, '0, '0, '0);       // untouched bin
    send_request(OP_ACCUM, 4'd0, 8'd0, 1'b1, 24'sh7FFFFF, 24'sh800000, 16'hFFFF);
    send_request(OP_ACCUM, 4'd0, 8'd0, 1'b1, 24'sh800000, 24'sh7FFFFF, 16'hFFFF);
    send_request(OP_ACCUM, 4'd15, 8'd255, 1'b1, -24'sd1, 24'sd1, 16'd1);  // rounding down
    send_request(OP_ACCUM, 4'd15, 8'd255, 1'b0, 24'sh7FFFFF, -24'sd3, 16'd0);
    send_request(OP_ACCUM, 4'd7, 8'd128, 1'b0, 24'sh123456, 24'shFEDCBA, 16'h8000);
    send_request(OP_RDBIN, 4'd0, 8'd0, 1'b0, '0, '0, '0);
    send_request(OP_RDBIN, 4'd15, 8'd255, 1'b0, '0, '0, '0);
    send_request(OP_RDBIN, 4'd7, 8'd128, 1'b0, '0, '0, '0);
    send_request(OP_RDTOT, 4'd0, 8'd0, 1'b0, '0, '0, '0);
    send_request(OP_ACCUM, 4'd3, 8'd9, 1'b1, 24'sd65536, 24'sd65536, 16'd4096);
    send_request(OP_RDTOT, 4'd0, 8'd0, 1'b0, '0, '0, '0);
    send_request(OP_CLEAR, 4'd0, 8'd0, 1'b0, '0, '0, '0);
    send_request(OP_RDBIN, 4'd0, 8'd0, 1'b0, '0, '0, '0);
    send_request(OP_RDTOT, 4'd0, 8'd0, 1'b0, '0, '0, '0);
    send_request(OP_ACCUM, 4'd1, 8'd1, 1'b1, 24'sd100, 24'sd200, 16'd0);  // zero weight row
    send_request(OP_RDTOT, 4'd0, 8'd0, 1'b0, '0, '0, '0);
    drain_reads();
  endtask

  // random requests; half the bins come from a small pool so reads hit data
  task automatic test_random(int n_items, int idle_pct, bit do_drain);
    logic [1:0]  op;
    logic [3:0]  feat;
    logic [7:0]  bin;
    logic [15:0] w;
    int          r;
    for (int i = 0; i < n_items; i++) begin
      r  = $urandom_range(999);
      op = (r < 4) ? OP_CLEAR : (r < 700) ? OP_ACCUM : (r < 900) ? OP_RDBIN : OP_RDTOT;
      if ($urandom_range(1)) begin
        feat = 4'($urandom_range(3));
        bin  = 8'($urandom_range(7));
      end else begin
        feat = 4'($urandom);
        bin  = 8'($urandom);
      end
      w = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom);
      send_request(op, feat, bin, 1'($urandom), 24'($urandom), 24'($urandom), w);
      if (do_drain && i == n_items / 2) drain_reads();
      if (int'($urandom_range(99)) < idle_pct) idle_sender($urandom_range(1, 6));
    end
    drain_reads();
  endtask

  initial begin
    clear_histogram();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(380, 0, 1'b1);
    test_random(370, 77, 1'b0);
    test_random(370, 0, 1'b0);
    test_random(370, 25, 1'b1);
    idle_sender(400);
    if (error_count == 0 && pending_reads.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
